/* hw/rtl/assert_macros.svh */
// Assertion macros shared by the checker files of the union-find engine.
// No dependencies; include by bare file name where assertions are written.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is switched off while the reset is high.
`define UFE_ASSERT(label, clk_s, rst_s, prop) \
  label: assert property (@(posedge clk_s) disable iff (rst_s) prop) \
    else $error("%m: assertion failed");

// Clocked assertion that also holds through reset.
`define UFE_ASSERT_NR(label, clk_s, prop) \
  label: assert property (@(posedge clk_s) prop) \
    else $error("%m: assertion failed");

`endif

/* hw/rtl/ufe_pkg.sv */
// Shared types and constants of the union-find engine.
// Used by the controller, the datapath and the top level; no dependencies.
package ufe_pkg;

  localparam int NODE_W        = 10;
  localparam int CNT_W         = 11;
  localparam int DEF_MAX_NODES = 1024;
  localparam int RESET_ACTIVE  = 1024;

  localparam int S_TDATA_W = 24;
  localparam int M_TDATA_W = 56;

  localparam logic CMD_UNITE = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  // Datapath operations issued by the controller.
  localparam int OP_W = 4;
  localparam logic [OP_W-1:0] OP_NONE       = 4'd0;
  localparam logic [OP_W-1:0] OP_CLR        = 4'd1;
  localparam logic [OP_W-1:0] OP_LOAD       = 4'd2;
  localparam logic [OP_W-1:0] OP_FIND_RD    = 4'd3;
  localparam logic [OP_W-1:0] OP_FIND_EV    = 4'd4;
  localparam logic [OP_W-1:0] OP_COMP_RD    = 4'd5;
  localparam logic [OP_W-1:0] OP_COMP_WR    = 4'd6;
  localparam logic [OP_W-1:0] OP_MERGE_LINK = 4'd7;
  localparam logic [OP_W-1:0] OP_MERGE_SIZE = 4'd8;
  localparam logic [OP_W-1:0] OP_RESULT     = 4'd9;

  typedef struct packed {
    logic [OP_W-1:0] op;
    logic            side;   // 0 works on the first node, 1 on the second
  } ufe_cmd_t;

  typedef struct packed {
    logic clr_last;   // clearing pass is at its last entry
    logic item_err;   // latched item has an index out of range
    logic rd_root;    // word read from the table is a root
    logic comp_skip;  // start node of the side is its own root
    logic comp_last;  // parent just read is the root
    logic do_merge;   // unite item with two different roots
    logic out_free;   // output register can take a result
  } ufe_stat_t;

endpackage

/* hw/rtl/ufe_ctrl.sv */
// Controller state machine of the union-find engine.
// Depends on ufe_pkg; drives ufe_datapath through command and status structs.
module ufe_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_wr_en,
  input  logic                in_valid,
  output logic                in_ready,
  input  ufe_pkg::ufe_stat_t  stat,
  output ufe_pkg::ufe_cmd_t   cmd
);
  import ufe_pkg::*;

  localparam logic [3:0] ST_CLEAR      = 4'd0;
  localparam logic [3:0] ST_IDLE       = 4'd1;
  localparam logic [3:0] ST_START      = 4'd2;
  localparam logic [3:0] ST_FIND_RD    = 4'd3;
  localparam logic [3:0] ST_FIND_EV    = 4'd4;
  localparam logic [3:0] ST_COMP_RD    = 4'd5;
  localparam logic [3:0] ST_COMP_WR    = 4'd6;
  localparam logic [3:0] ST_MERGE_LINK = 4'd7;
  localparam logic [3:0] ST_MERGE_SIZE = 4'd8;
  localparam logic [3:0] ST_RESULT     = 4'd9;

  logic [3:0] state, state_next;
  logic       side, side_next;

  assign in_ready = (state == ST_IDLE);

  always_comb begin
    state_next = state;
    side_next  = side;
    cmd.op     = OP_NONE;
    cmd.side   = side;
    unique case (state) inside
      ST_CLEAR: begin
        cmd.op = OP_CLR;
        if (stat.clr_last) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid) begin
          cmd.op     = OP_LOAD;
          state_next = ST_START;
        end
      end
      ST_START: begin
        side_next  = 1'b0;
        state_next = stat.item_err ? ST_RESULT : ST_FIND_RD;
      end
      ST_FIND_RD: begin
        cmd.op     = OP_FIND_RD;
        state_next = ST_FIND_EV;
      end
      ST_FIND_EV: begin
        cmd.op = OP_FIND_EV;
        if (stat.rd_root) state_next = ST_COMP_RD;
      end
      ST_COMP_RD, ST_COMP_WR: begin
        cmd.op = (state == ST_COMP_RD) ? OP_COMP_RD : OP_COMP_WR;
        if ((state == ST_COMP_RD && stat.comp_skip) ||
            (state == ST_COMP_WR && stat.comp_last)) begin
          if (!side) begin
            side_next  = 1'b1;
            state_next = ST_FIND_RD;
          end else begin
            state_next = stat.do_merge ? ST_MERGE_LINK : ST_RESULT;
          end
        end else begin
          state_next = ST_COMP_WR;
        end
      end
      ST_MERGE_LINK: begin
        cmd.op     = OP_MERGE_LINK;
        state_next = ST_MERGE_SIZE;
      end
      ST_MERGE_SIZE: begin
        cmd.op     = OP_MERGE_SIZE;
        state_next = ST_RESULT;
      end
      ST_RESULT: begin
        cmd.op = OP_RESULT;
        if (stat.out_free) state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_CLEAR;
      end
    endcase
    // A register write restarts the clearing pass.
    if (cfg_wr_en) state_next = ST_CLEAR;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
      side  <= 1'b0;
    end else begin
      state <= state_next;
      side  <= side_next;
    end
  end

endmodule

/* hw/rtl/ufe_datapath.sv */
// Datapath of the union-find engine: link table memory, walk registers,
// merge arithmetic and output register. Depends on ufe_pkg.
module ufe_datapath #(
  parameter int MAX_NODES = ufe_pkg::DEF_MAX_NODES
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_wr_en,
  input  logic [ufe_pkg::CNT_W-1:0]  cfg_wr_data,
  input  logic                       in_command,
  input  logic [ufe_pkg::NODE_W-1:0] in_node_a,
  input  logic [ufe_pkg::NODE_W-1:0] in_node_b,
  input  ufe_pkg::ufe_cmd_t          cmd,
  output ufe_pkg::ufe_stat_t         stat,
  input  logic                       out_ready,
  output logic                       out_valid,
  output logic                       out_error,
  output logic                       out_were_same,
  output logic                       out_merged,
  output logic [ufe_pkg::NODE_W-1:0] out_surviving_root,
  output logic [ufe_pkg::NODE_W-1:0] out_absorbed_root,
  output logic [ufe_pkg::CNT_W-1:0]  out_size_a,
  output logic [ufe_pkg::CNT_W-1:0]  out_size_b,
  output logic [ufe_pkg::CNT_W-1:0]  out_component_count
);
  import ufe_pkg::*;

  localparam int IW = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
  localparam int SW = $clog2(MAX_NODES + 1);
  localparam int WW = SW + 1;
  localparam int ACTIVE_RST = (RESET_ACTIVE > MAX_NODES) ? MAX_NODES : RESET_ACTIVE;

  // Table word: top bit marks a root; a root holds its set size, others a parent.
  logic [WW-1:0] mem [MAX_NODES];
  logic [WW-1:0] rd_data;
  logic [IW-1:0] rd_addr;
  logic          wr_en;
  logic [IW-1:0] wr_addr;
  logic [WW-1:0] wr_data;

  logic              cmd_q;
  logic [NODE_W-1:0] node_a, node_b;
  logic              err_q;
  logic              merged_q;
  logic [IW-1:0]     cur;
  logic [IW-1:0]     root_a, root_b;
  logic [SW-1:0]     size_a, size_b;
  logic [IW-1:0]     clr_idx;
  logic [SW-1:0]     active;
  logic [SW-1:0]     comp_total;

  logic [IW-1:0] node_idx, root_sel, rd_parent, winner, loser;
  logic [SW-1:0] size_sum, cfg_count;
  logic          rd_root, a_wins, in_err, out_free;

  assign node_idx  = IW'(cmd.side ? node_b : node_a);
  assign root_sel  = cmd.side ? root_b : root_a;
  assign rd_root   = rd_data[WW-1];
  assign rd_parent = rd_data[IW-1:0];
  assign a_wins    = (size_a >= size_b);
  assign winner    = a_wins ? root_a : root_b;
  assign loser     = a_wins ? root_b : root_a;
  assign size_sum  = size_a + size_b;
  assign in_err    = (32'(in_node_a) >= 32'(active)) || (32'(in_node_b) >= 32'(active));
  assign out_free  = !out_valid || out_ready;

  always_comb begin
    if (cfg_wr_data == '0) begin
      cfg_count = SW'(1);
    end else if (32'(cfg_wr_data) > 32'(MAX_NODES)) begin
      cfg_count = SW'(MAX_NODES);
    end else begin
      cfg_count = SW'(cfg_wr_data);
    end
  end

  assign stat.clr_last  = (clr_idx == IW'(MAX_NODES - 1));
  assign stat.item_err  = err_q;
  assign stat.rd_root   = rd_root;
  assign stat.comp_skip = (node_idx == root_sel);
  assign stat.comp_last = (rd_parent == root_sel);
  assign stat.do_merge  = (cmd_q == CMD_UNITE) && (root_a != root_b);
  assign stat.out_free  = out_free;

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = cur;
    wr_data = {1'b0, SW'(root_sel)};
    unique case (cmd.op)
      OP_CLR: begin
        wr_en   = 1'b1;
        wr_addr = clr_idx;
        wr_data = {1'b1, SW'(1)};
      end
      OP_COMP_WR: begin
        wr_en = 1'b1;
      end
      OP_MERGE_LINK: begin
        wr_en   = 1'b1;
        wr_addr = loser;
        wr_data = {1'b0, SW'(winner)};
      end
      OP_MERGE_SIZE: begin
        wr_en   = 1'b1;
        wr_addr = winner;
        wr_data = {1'b1, size_sum};
      end
      default: begin
        wr_en = 1'b0;
      end
    endcase
  end

  always_comb begin
    unique case (cmd.op) inside
      OP_FIND_RD, OP_COMP_RD: rd_addr = node_idx;
      OP_FIND_EV, OP_COMP_WR: rd_addr = rd_parent;
      default:                rd_addr = cur;
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    rd_data <= mem[rd_addr];
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_idx    <= '0;
      active     <= SW'(ACTIVE_RST);
      comp_total <= SW'(ACTIVE_RST);
      out_valid  <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        active     <= cfg_count;
        comp_total <= cfg_count;
        clr_idx    <= '0;
      end else begin
        if (cmd.op == OP_CLR) clr_idx <= clr_idx + IW'(1);
        if (cmd.op == OP_MERGE_SIZE && comp_total != '0) comp_total <= comp_total - SW'(1);
      end
      if (cmd.op == OP_RESULT && out_free) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    case (cmd.op) inside
      OP_LOAD: begin
        cmd_q    <= in_command;
        node_a   <= in_node_a;
        node_b   <= in_node_b;
        err_q    <= in_err;
        merged_q <= 1'b0;
      end
      OP_FIND_RD, OP_COMP_RD: begin
        cur <= node_idx;
      end
      OP_FIND_EV: begin
        if (rd_root) begin
          if (cmd.side) begin
            root_b <= cur;
            size_b <= rd_data[SW-1:0];
          end else begin
            root_a <= cur;
            size_a <= rd_data[SW-1:0];
          end
        end else begin
          cur <= rd_parent;
        end
      end
      OP_COMP_WR: begin
        cur <= rd_parent;
      end
      OP_MERGE_SIZE: begin
        merged_q <= 1'b1;
      end
      OP_RESULT: begin
        if (out_free) begin
          out_component_count <= CNT_W'(comp_total);
          if (err_q) begin
            out_error          <= 1'b1;
            out_were_same      <= 1'b0;
            out_merged         <= 1'b0;
            out_surviving_root <= '0;
            out_absorbed_root  <= '0;
            out_size_a         <= '0;
            out_size_b         <= '0;
          end else begin
            out_error          <= 1'b0;
            out_were_same      <= (root_a == root_b);
            out_merged         <= merged_q;
            out_surviving_root <= NODE_W'(merged_q ? winner : root_a);
            out_absorbed_root  <= merged_q ? NODE_W'(loser) : '0;
            out_size_a         <= CNT_W'(merged_q ? size_sum : size_a);
            out_size_b         <= CNT_W'(merged_q ? size_sum : size_b);
          end
        end
      end
      default: begin
      end
    endcase
  end

endmodule

/* hw/rtl/union_find_engine_unit.sv */
// Top level of the union-find engine: controller plus datapath.
// Depends on ufe_pkg, ufe_ctrl and ufe_datapath.
//
// Usage: the block keeps a disjoint-set forest over MAX_NODES nodes.
// The slave stream carries one item per transfer: tuser is the command
// (unite or query) and tdata holds the two node indices. The master stream
// returns exactly one result transfer per item: tuser is the error flag
// and tdata the sameness, merge, root, size and component-count fields.
// A result is loaded once the find walk and the path compression of both
// nodes are done (a find step and a compression step for each link on a
// node's path to the root), plus a link and a size write when a unite merges
// two sets. The next item can be taken in the cycle after its result is
// loaded; path compression shortens the walks of later items.
// An item that names a node at or above active_nodes changes nothing and
// returns an error without walking the table.
// Reset and every write of active_nodes start a clearing pass over all MAX_NODES
// entries that turns every node into a singleton; no item is taken meanwhile.
// The result sits in an output register: a new item is taken while it waits,
// and the engine holds before delivering the next result until the receiver
// has taken the pending one.
module union_find_engine_unit #(
  parameter int MAX_NODES = ufe_pkg::DEF_MAX_NODES
) (
  input  logic                          clk,
  input  logic                          rst,
  // active_nodes register write.
  input  logic                          cfg_wr_en,
  input  logic [ufe_pkg::CNT_W-1:0]     cfg_wr_data,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // node_a [9:0], node_b [19:10], zero [23:20]
  input  logic [ufe_pkg::S_TDATA_W-1:0] s_axis_tdata,
  // command [0]
  input  logic                          s_axis_tuser,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // were_same [0], merged [1], surviving_root [11:2], absorbed_root [21:12],
  // size_a [32:22], size_b [43:33], component_count [54:44], zero [55]
  output logic [ufe_pkg::M_TDATA_W-1:0] m_axis_tdata,
  // error [0]
  output logic                          m_axis_tuser
);
  import ufe_pkg::*;

  ufe_cmd_t  cmd;
  ufe_stat_t stat;

  logic              out_were_same, out_merged;
  logic [NODE_W-1:0] out_surviving_root, out_absorbed_root;
  logic [CNT_W-1:0]  out_size_a, out_size_b, out_component_count;

  // The controller sequences find, compression, merge and result steps.
  ufe_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cfg_wr_en (cfg_wr_en),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  // The datapath owns the link table and all item registers.
  ufe_datapath #(
    .MAX_NODES (MAX_NODES)
  ) u_datapath (
    .clk                 (clk),
    .rst                 (rst),
    .cfg_wr_en           (cfg_wr_en),
    .cfg_wr_data         (cfg_wr_data),
    .in_command          (s_axis_tuser),
    .in_node_a           (s_axis_tdata[NODE_W-1:0]),
    .in_node_b           (s_axis_tdata[2*NODE_W-1:NODE_W]),
    .cmd                 (cmd),
    .stat                (stat),
    .out_ready           (m_axis_tready),
    .out_valid           (m_axis_tvalid),
    .out_error           (m_axis_tuser),
    .out_were_same       (out_were_same),
    .out_merged          (out_merged),
    .out_surviving_root  (out_surviving_root),
    .out_absorbed_root   (out_absorbed_root),
    .out_size_a          (out_size_a),
    .out_size_b          (out_size_b),
    .out_component_count (out_component_count)
  );

  // Result fields packed from the lowest bit up, padded to whole bytes.
  assign m_axis_tdata = {1'b0, out_component_count, out_size_b, out_size_a,
                         out_absorbed_root, out_surviving_root,
                         out_merged, out_were_same};

endmodule

/* hw/rtl/ufe_checker.sv */
// Port-level assertion checker of the union-find engine, bound to the top.
// Depends on assert_macros.svh and ufe_pkg.
`include "assert_macros.svh"

module ufe_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          cfg_wr_en,
  input logic                          s_axis_tready,
  input logic                          m_axis_tvalid,
  input logic                          m_axis_tready,
  input logic [ufe_pkg::M_TDATA_W-1:0] m_axis_tdata,
  input logic                          m_axis_tuser
);
  import ufe_pkg::*;

  // Result fields picked out of tdata.
  logic             res_same, res_merged;
  logic [43:0]      res_body;
  logic [CNT_W-1:0] res_size_a, res_size_b;

  assign res_same   = m_axis_tdata[0];
  assign res_merged = m_axis_tdata[1];
  assign res_body   = m_axis_tdata[43:0];
  assign res_size_a = m_axis_tdata[32:22];
  assign res_size_b = m_axis_tdata[43:33];

  // A pending result is not withdrawn before the receiver takes it.
  `UFE_ASSERT(a_out_hold, clk, rst, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)

  // Reset starts the clearing pass, so no item is taken right after it.
  `UFE_ASSERT_NR(a_clear_after_rst, clk, rst |=> !s_axis_tready)

  // A register write clears the table, so the next cycle takes no item.
  `UFE_ASSERT(a_clear_after_cfg, clk, rst, cfg_wr_en |=> !s_axis_tready)

  // An error result carries only the component count.
  `UFE_ASSERT(a_err_payload, clk, rst, m_axis_tvalid && m_axis_tuser |-> res_body == '0)

  // A merge joins two different sets that then report one common size.
  `UFE_ASSERT(a_merge_sizes, clk, rst, m_axis_tvalid && res_merged |-> !res_same && (res_size_a == res_size_b))

endmodule

bind union_find_engine_unit ufe_checker u_ufe_checker (
  .clk           (clk),
  .rst           (rst),
  .cfg_wr_en     (cfg_wr_en),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);
